// ----- src/dlmt_pkg.sv -----
// Shared constants, types and helper functions of the DFA longest-match tokenizer.
`timescale 1ns / 1ps

package dlmt_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_SYMBOLS = 128;
    localparam int LENGTH_BITS = 16;

    localparam int STORE_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int STATE_W     = $clog2(NUM_STATES);
    localparam int SYM_W       = $clog2(NUM_SYMBOLS);
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int ROW_W     = 6;
    localparam int COL_W     = 7;
    localparam int CELL_W    = 7;
    localparam int CODE_W    = 8;
    localparam int OUT_LEN_W = 16;

    localparam logic [CELL_W-1:0] NO_NEXT = {CELL_W{1'b1}};
    localparam logic [CODE_W-1:0] NUL_CHAR = '0;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    typedef struct packed {
        logic              active;
        logic [ADDR_W-1:0] addr;
        logic              acc_we;
    } t_clr;

    typedef struct packed {
        logic               valid;
        logic               first;
        logic [STATE_W-1:0] start;
        logic               start_ok;
        logic               code_ok;
        logic [SYM_W-1:0]   code;
    } t_scan_beat;

    typedef struct packed {
        logic              re;
        logic [ADDR_W-1:0] addr;
    } t_trans_rd;

    typedef struct packed {
        logic               re;
        logic [STATE_W-1:0] addr;
    } t_acc_rd;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [STATE_W-1:0] state,
                                                    input logic [SYM_W-1:0] col);
        cell_addr = ADDR_W'(state) * ADDR_W'(NUM_SYMBOLS) + ADDR_W'(col);
    endfunction

endpackage

// ----- src/dfa_longest_match_tokenizer_top.sv -----
// Top level of the table-driven DFA longest-match tokenizer.
// A scan character is held in the lookup stage while its transition is read; the input
// stalls meanwhile, as that read gives the state address of the following character,
// and an output stall can keep it there. The character that ends the scan puts its
// result beat into the result register. Reset: a clearing pass sets every cell to no
// transition and every accept flag, and no input beat is taken until it has finished.
`timescale 1ns / 1ps

module dfa_longest_match_tokenizer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_operation,
    input  logic [dlmt_pkg::ROW_W-1:0]        i_table_row,
    input  logic [dlmt_pkg::COL_W-1:0]        i_table_column,
    input  logic signed [dlmt_pkg::CELL_W-1:0] i_cell_value,
    input  logic                              i_first_char,
    input  logic [dlmt_pkg::ROW_W-1:0]        i_start_state,
    input  logic [dlmt_pkg::CODE_W-1:0]       i_char_code,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_found,
    output logic [dlmt_pkg::OUT_LEN_W-1:0]    o_match_length
);

    dlmt_pkg::t_clr       clr;
    dlmt_pkg::t_scan_beat beat;
    dlmt_pkg::t_trans_rd  trans_rd;
    dlmt_pkg::t_acc_rd    acc_rd;

    logic                          busy;
    logic                          in_acc;
    logic                          wr_ok;
    logic [dlmt_pkg::ADDR_W-1:0]   wr_addr;
    logic                          trans_we;
    logic [dlmt_pkg::ADDR_W-1:0]   trans_waddr;
    logic [dlmt_pkg::CELL_W-1:0]   trans_wdata;
    logic [dlmt_pkg::CELL_W-1:0]   trans_rdata;
    logic                          acc_we;
    logic [dlmt_pkg::STATE_W-1:0]  acc_waddr;
    logic                          acc_wdata;
    logic                          acc_rdata;

    dlmt_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .o_clr   (clr)
    );

    assign o_stall = clr.active || busy;
    assign in_acc  = i_valid && !o_stall;

    assign wr_ok   = (32'(i_table_row) < dlmt_pkg::NUM_STATES)
                     && (32'(i_table_column) < dlmt_pkg::NUM_SYMBOLS);
    assign wr_addr = dlmt_pkg::cell_addr(dlmt_pkg::STATE_W'(i_table_row),
                                         dlmt_pkg::SYM_W'(i_table_column));

    always_comb begin
        if (clr.active) begin
            trans_we    = 1'b1;
            trans_waddr = clr.addr;
            trans_wdata = dlmt_pkg::NO_NEXT;
            acc_we      = clr.acc_we;
            acc_waddr   = dlmt_pkg::STATE_W'(clr.addr);
            acc_wdata   = 1'b1;
        end else begin
            trans_we    = in_acc && (i_operation == dlmt_pkg::OP_WRITE) && wr_ok;
            trans_waddr = wr_addr;
            trans_wdata = i_cell_value;
            acc_we      = trans_we && (i_table_column == '0);
            acc_waddr   = dlmt_pkg::STATE_W'(i_table_row);
            acc_wdata   = (i_cell_value != '0);
        end
    end

    assign beat.valid    = in_acc && (i_operation == dlmt_pkg::OP_SCAN);
    assign beat.first    = i_first_char;
    assign beat.start    = dlmt_pkg::STATE_W'(i_start_state);
    assign beat.start_ok = 32'(i_start_state) < dlmt_pkg::NUM_STATES;
    assign beat.code_ok  = (i_char_code != dlmt_pkg::NUL_CHAR) && !i_char_code[7]
                           && (32'(i_char_code) < dlmt_pkg::NUM_SYMBOLS);
    assign beat.code     = dlmt_pkg::SYM_W'(i_char_code);

    dlmt_ram #(
        .WIDTH (dlmt_pkg::CELL_W),
        .DEPTH (dlmt_pkg::STORE_DEPTH)
    ) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (trans_we),
        .i_waddr (trans_waddr),
        .i_wdata (trans_wdata),
        .i_re    (trans_rd.re),
        .i_raddr (trans_rd.addr),
        .o_rdata (trans_rdata)
    );

    dlmt_ram #(
        .WIDTH (1),
        .DEPTH (dlmt_pkg::NUM_STATES)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_re    (acc_rd.re),
        .i_raddr (acc_rd.addr),
        .o_rdata (acc_rdata)
    );

    dlmt_scan u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat         (beat),
        .i_trans_data   (trans_rdata),
        .i_acc_data     (acc_rdata),
        .i_out_stall    (i_stall),
        .o_trans_rd     (trans_rd),
        .o_acc_rd       (acc_rd),
        .o_busy         (busy),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_match_length (o_match_length)
    );

    // A scan beat occupies the lookup stage in the following cycle.
    a_scan_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat.valid |=> busy)
        else $error("scan beat did not occupy the lookup stage");

    // The clearing pass never shares the table with a lookup.
    a_clear_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr.active |-> !trans_rd.re && !acc_rd.re)
        else $error("table read during the clearing pass");

    // A new result beat only follows a character held in the lookup stage.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result beat without a preceding scan character");

    // No match means a length of zero.
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_match_length == '0))
        else $error("nonzero length without a match");

endmodule

// ----- src/dlmt_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module dlmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/dlmt_clear.sv -----
// Clearing sweep that sets every table cell to no transition after reset and also drives the accept-flag writes.
`timescale 1ns / 1ps

module dlmt_clear (
    input  logic          i_clk,
    input  logic          i_rst_n,
    output dlmt_pkg::t_clr o_clr
);

    logic                        r_active;
    logic                        n_active;
    logic [dlmt_pkg::ADDR_W-1:0] r_cnt;
    logic [dlmt_pkg::ADDR_W-1:0] n_cnt;

    always_comb begin
        n_active = r_active;
        n_cnt    = r_cnt;
        if (r_active) begin
            if (r_cnt == dlmt_pkg::ADDR_W'(dlmt_pkg::STORE_DEPTH - 1)) begin
                n_active = 1'b0;
            end else begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b1;
            r_cnt    <= '0;
        end else begin
            r_active <= n_active;
            r_cnt    <= n_cnt;
        end
    end

    assign o_clr.active = r_active;
    assign o_clr.addr   = r_cnt;
    assign o_clr.acc_we = r_active && (32'(r_cnt) < dlmt_pkg::NUM_STATES);

endmodule

// ----- src/dlmt_scan.sv -----
// Scan pipeline: transition lookup, accept-flag lookup, match tracking and result register.
`timescale 1ns / 1ps

module dlmt_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dlmt_pkg::t_scan_beat          i_beat,
    input  logic [dlmt_pkg::CELL_W-1:0]   i_trans_data,
    input  logic                          i_acc_data,
    input  logic                          i_out_stall,
    output dlmt_pkg::t_trans_rd           o_trans_rd,
    output dlmt_pkg::t_acc_rd             o_acc_rd,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [dlmt_pkg::OUT_LEN_W-1:0] o_match_length
);

    logic                             r_s1_valid;
    logic                             n_s1_valid;
    logic                             r_s1_first;
    logic                             r_s1_start_ok;
    logic                             r_s1_code_ok;
    logic [dlmt_pkg::STATE_W-1:0]     r_state;
    logic [dlmt_pkg::STATE_W-1:0]     n_state;
    logic                             r_active;
    logic                             n_active;
    logic [dlmt_pkg::LENGTH_BITS-1:0] r_count;
    logic [dlmt_pkg::LENGTH_BITS-1:0] n_count;
    logic                             r_best_found;
    logic                             n_best_found;
    logic [dlmt_pkg::LENGTH_BITS-1:0] r_best_len;
    logic [dlmt_pkg::LENGTH_BITS-1:0] n_best_len;
    logic                             r_s2_valid;
    logic                             n_s2_valid;
    logic                             r_o_valid;
    logic                             n_o_valid;
    logic                             r_o_found;
    logic                             n_o_found;
    logic [dlmt_pkg::OUT_LEN_W-1:0]   r_o_len;
    logic [dlmt_pkg::OUT_LEN_W-1:0]   n_o_len;

    logic                             s1_active;
    logic                             next_ok;
    logic                             dead;
    logic                             out_free;
    logic                             emit;
    logic                             hold;
    logic                             step;
    logic [dlmt_pkg::STATE_W-1:0]     next_state;
    logic [dlmt_pkg::LENGTH_BITS-1:0] cnt_base;
    logic [dlmt_pkg::LENGTH_BITS-1:0] len_base;
    logic                             found_base;

    always_comb begin
        s1_active  = r_s1_first || r_active;
        next_ok    = !i_trans_data[dlmt_pkg::CELL_W-1]
                     && (32'(i_trans_data[dlmt_pkg::CELL_W-2:0]) < dlmt_pkg::NUM_STATES);
        next_state = dlmt_pkg::STATE_W'(i_trans_data[dlmt_pkg::CELL_W-2:0]);
        dead       = !r_s1_code_ok || (r_s1_first && !r_s1_start_ok) || !next_ok;
        out_free   = !r_o_valid || !i_out_stall;
        emit       = r_s1_valid && s1_active && dead;
        hold       = emit && !out_free;
        step       = r_s1_valid && s1_active && !dead;
        cnt_base   = r_s1_first ? '0 : r_count;
        len_base   = r_s1_first ? '0 : r_best_len;
        found_base = r_s1_first ? 1'b0 : r_best_found;

        n_s1_valid   = i_beat.valid || hold;
        n_state      = r_state;
        n_active     = r_active;
        n_count      = r_count;
        n_best_found = r_best_found;
        n_best_len   = r_best_len;
        n_s2_valid   = 1'b0;
        n_o_valid    = r_o_valid && i_out_stall;
        n_o_found    = r_o_found;
        n_o_len      = r_o_len;

        if (emit && out_free) begin
            n_active     = 1'b0;
            n_count      = cnt_base;
            n_best_found = found_base;
            n_best_len   = len_base;
            n_o_valid    = 1'b1;
            n_o_found    = found_base;
            n_o_len      = found_base ? dlmt_pkg::OUT_LEN_W'(len_base) : '0;
        end

        if (step) begin
            n_state      = next_state;
            n_active     = 1'b1;
            n_count      = (cnt_base == '1) ? cnt_base : cnt_base + 1'b1;
            n_best_found = found_base;
            n_best_len   = len_base;
            n_s2_valid   = 1'b1;
        end

        if (r_s2_valid && i_acc_data) begin
            n_best_found = 1'b1;
            n_best_len   = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_state      <= '0;
            r_active     <= 1'b0;
            r_count      <= '0;
            r_best_found <= 1'b0;
            r_best_len   <= '0;
            r_s2_valid   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_s1_valid   <= n_s1_valid;
            r_state      <= n_state;
            r_active     <= n_active;
            r_count      <= n_count;
            r_best_found <= n_best_found;
            r_best_len   <= n_best_len;
            r_s2_valid   <= n_s2_valid;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_beat.valid) begin
            r_s1_first    <= i_beat.first;
            r_s1_start_ok <= i_beat.start_ok;
            r_s1_code_ok  <= i_beat.code_ok;
        end
        r_o_found <= n_o_found;
        r_o_len   <= n_o_len;
    end

    assign o_trans_rd.re   = i_beat.valid && i_beat.code_ok;
    assign o_trans_rd.addr = dlmt_pkg::cell_addr(i_beat.first ? i_beat.start : r_state,
                                                 i_beat.code);
    assign o_acc_rd.re     = step;
    assign o_acc_rd.addr   = next_state;

    assign o_busy         = r_s1_valid;
    assign o_valid        = r_o_valid;
    assign o_found        = r_o_found;
    assign o_match_length = r_o_len;

endmodule

// ----- verif/dfa_longest_match_tokenizer_top_test.sv -----
// Self-checking testbench for the DFA longest-match tokenizer top level.
`timescale 1ns / 1ps

module dfa_longest_match_tokenizer_top_test;

    typedef struct {
        logic                           found;
        logic [dlmt_pkg::OUT_LEN_W-1:0] length;
    } t_match;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    logic                               i_operation;
    logic [dlmt_pkg::ROW_W-1:0]         i_table_row;
    logic [dlmt_pkg::COL_W-1:0]         i_table_column;
    logic signed [dlmt_pkg::CELL_W-1:0] i_cell_value;
    logic                               i_first_char;
    logic [dlmt_pkg::ROW_W-1:0]         i_start_state;
    logic [dlmt_pkg::CODE_W-1:0]        i_char_code;
    logic                               o_valid;
    logic                               i_stall;
    logic                               o_found;
    logic [dlmt_pkg::OUT_LEN_W-1:0]     o_match_length;

    logic signed [dlmt_pkg::CELL_W-1:0] cell_table [0:dlmt_pkg::NUM_STATES-1]
                                                   [0:dlmt_pkg::NUM_SYMBOLS-1];
    logic [dlmt_pkg::STATE_W-1:0]       dfa_state;
    logic                               scan_on;
    logic [dlmt_pkg::LENGTH_BITS-1:0]   scanned;
    logic [dlmt_pkg::LENGTH_BITS-1:0]   longest;
    logic                               accepted;

    t_match                             pending_matches[$];
    logic [dlmt_pkg::ROW_W-1:0]         state_set[$];
    logic [dlmt_pkg::CODE_W-1:0]        alphabet[$];
    int                                 mismatches;
    int                                 beats_sent;
    bit                                 quiet;

    dfa_longest_match_tokenizer_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_operation    (i_operation),
        .i_table_row    (i_table_row),
        .i_table_column (i_table_column),
        .i_cell_value   (i_cell_value),
        .i_first_char   (i_first_char),
        .i_start_state  (i_start_state),
        .i_char_code    (i_char_code),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_found        (o_found),
        .o_match_length (o_match_length)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #20ms;
        $display("dfa_longest_match_tokenizer_top test failed");
        $finish;
    end

    always @(negedge i_clk) begin
        i_stall <= quiet ? 1'b0 : ($urandom_range(99) < 26);
    end

    always @(posedge i_clk) begin
        t_match want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_matches.size() == 0) begin
                $error("result beat with no expected match: found %0d length %0d",
                       o_found, o_match_length);
                mismatches++;
            end else begin
                want = pending_matches.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, actual %0d", want.found, o_found);
                    mismatches++;
                end
                if (o_match_length !== want.length) begin
                    $error("match_length: expected %0d, actual %0d", want.length,
                           o_match_length);
                    mismatches++;
                end
            end
        end
    end

    task automatic close_scan();
        t_match m;
        scan_on  = 1'b0;
        m.found  = accepted;
        m.length = accepted ? dlmt_pkg::OUT_LEN_W'(longest) : '0;
        pending_matches.push_back(m);
    endtask

    task automatic advance_tokenizer(input logic op, input logic [dlmt_pkg::ROW_W-1:0] row,
                                     input logic [dlmt_pkg::COL_W-1:0] col,
                                     input logic signed [dlmt_pkg::CELL_W-1:0] val,
                                     input logic first,
                                     input logic [dlmt_pkg::ROW_W-1:0] start,
                                     input logic [dlmt_pkg::CODE_W-1:0] code);
        logic signed [dlmt_pkg::CELL_W-1:0] next;
        if (op == dlmt_pkg::OP_WRITE) begin
            if (int'(row) < dlmt_pkg::NUM_STATES && int'(col) < dlmt_pkg::NUM_SYMBOLS)
                cell_table[row][col] = val;
        end else begin
            if (first) begin
                dfa_state = dlmt_pkg::STATE_W'(start);
                scan_on   = 1'b1;
                scanned   = '0;
                longest   = '0;
                accepted  = 1'b0;
            end
            if (scan_on) begin
                if (code == dlmt_pkg::NUL_CHAR || code >= 8'd128 ||
                    int'(code) >= dlmt_pkg::NUM_SYMBOLS ||
                    int'(start) >= dlmt_pkg::NUM_STATES && first) begin
                    close_scan();
                end else begin
                    next = cell_table[dfa_state][code[dlmt_pkg::SYM_W-1:0]];
                    if (next < 0 || int'(next) >= dlmt_pkg::NUM_STATES) begin
                        close_scan();
                    end else begin
                        dfa_state = dlmt_pkg::STATE_W'(next);
                        if (scanned != {dlmt_pkg::LENGTH_BITS{1'b1}})
                            scanned = scanned + 1'b1;
                        if (cell_table[dfa_state][0] != 0) begin
                            accepted = 1'b1;
                            longest  = scanned;
                        end
                    end
                end
            end
        end
    endtask

    task automatic drive_item(input logic op, input logic [dlmt_pkg::ROW_W-1:0] row,
                              input logic [dlmt_pkg::COL_W-1:0] col,
                              input logic signed [dlmt_pkg::CELL_W-1:0] val,
                              input logic first, input logic [dlmt_pkg::ROW_W-1:0] start,
                              input logic [dlmt_pkg::CODE_W-1:0] code);
        while (!quiet && $urandom_range(99) < 26) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_operation    <= op;
        i_table_row    <= row;
        i_table_column <= col;
        i_cell_value   <= val;
        i_first_char   <= first;
        i_start_state  <= start;
        i_char_code    <= code;
        i_valid        <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_tokenizer(op, row, col, val, first, start, code);
        @(negedge i_clk);
    endtask

    task automatic write_cell(input logic [dlmt_pkg::ROW_W-1:0] row,
                              input logic [dlmt_pkg::COL_W-1:0] col,
                              input logic signed [dlmt_pkg::CELL_W-1:0] val);
        beats_sent++;
        drive_item(dlmt_pkg::OP_WRITE, row, col, val, 1'($urandom),
                   dlmt_pkg::ROW_W'($urandom), dlmt_pkg::CODE_W'($urandom));
    endtask

    task automatic scan_char(input logic first, input logic [dlmt_pkg::ROW_W-1:0] start,
                             input logic [dlmt_pkg::CODE_W-1:0] code);
        beats_sent++;
        drive_item(dlmt_pkg::OP_SCAN, dlmt_pkg::ROW_W'($urandom),
                   dlmt_pkg::COL_W'($urandom), dlmt_pkg::CELL_W'($urandom),
                   first, start, code);
    endtask

    function automatic logic [dlmt_pkg::CODE_W-1:0] pick_letter();
        int roll;
        roll = $urandom_range(99);
        if (roll < 85)
            return alphabet[$urandom_range(alphabet.size() - 1)];
        else if (roll < 95)
            return dlmt_pkg::CODE_W'($urandom_range(127, 1));
        return dlmt_pkg::CODE_W'($urandom_range(255));
    endfunction

    function automatic logic signed [dlmt_pkg::CELL_W-1:0] pick_next();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return dlmt_pkg::CELL_W'(state_set[$urandom_range(state_set.size() - 1)]);
        else if (roll < 88)
            return -1;
        else if (roll < 94)
            return dlmt_pkg::CELL_W'(-int'($urandom_range(64, 2)));
        return dlmt_pkg::CELL_W'($urandom_range(63));
    endfunction

    function automatic logic signed [dlmt_pkg::CELL_W-1:0] pick_flag();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return 0;
        else if (roll < 70)
            return dlmt_pkg::CELL_W'($urandom_range(63, 1));
        else if (roll < 85)
            return -1;
        return dlmt_pkg::CELL_W'(-int'($urandom_range(64, 2)));
    endfunction

    task automatic test_directed();
        scan_char(1'b0, 0, 8'd97);
        scan_char(1'b1, 0, dlmt_pkg::NUL_CHAR);
        scan_char(1'b1, 0, 8'd255);
        scan_char(1'b1, 0, 8'd128);
        scan_char(1'b1, 0, 8'd97);
        write_cell(0, 97, 1);
        scan_char(1'b1, 0, 8'd97);
        scan_char(1'b0, 0, 8'd98);
        write_cell(1, 0, 0);
        write_cell(1, 127, 63);
        write_cell(63, 0, 63);
        write_cell(63, 1, -64);
        scan_char(1'b1, 0, 8'd97);
        scan_char(1'b0, 0, 8'd127);
        scan_char(1'b0, 0, 8'd1);
        scan_char(1'b1, 0, 8'd97);
        scan_char(1'b1, 0, 8'd97);
        write_cell(5, 5, 3);
        scan_char(1'b0, 0, 8'd127);
        scan_char(1'b0, 0, 8'd200);
        write_cell(63, 127, 0);
        scan_char(1'b1, 63, 8'd127);
        scan_char(1'b0, 0, dlmt_pkg::NUL_CHAR);
        scan_char(1'b0, 0, 8'd97);
    endtask

    task automatic test_long_scan();
        quiet = 1'b1;
        write_cell(2, 65, 2);
        write_cell(2, 0, 1);
        scan_char(1'b1, 2, 8'd65);
        repeat (300) scan_char(1'b0, dlmt_pkg::ROW_W'($urandom), 8'd65);
        scan_char(1'b0, 0, dlmt_pkg::NUL_CHAR);
        quiet = 1'b0;
    endtask

    task automatic random_round();
        int  n_scans;
        int  len;
        int  roll;
        logic [dlmt_pkg::ROW_W-1:0] from;
        state_set.delete();
        alphabet.delete();
        repeat ($urandom_range(6, 2))
            state_set.push_back(dlmt_pkg::ROW_W'($urandom_range(63)));
        repeat ($urandom_range(5, 2))
            alphabet.push_back(dlmt_pkg::CODE_W'($urandom_range(127, 1)));
        foreach (state_set[i]) begin
            write_cell(state_set[i], 0, pick_flag());
            foreach (alphabet[j])
                write_cell(state_set[i], alphabet[j][dlmt_pkg::COL_W-1:0], pick_next());
        end
        n_scans = $urandom_range(8, 3);
        repeat (n_scans) begin
            if ($urandom_range(99) < 10)
                drive_item(dlmt_pkg::OP_SCAN, dlmt_pkg::ROW_W'($urandom),
                           dlmt_pkg::COL_W'($urandom), dlmt_pkg::CELL_W'($urandom),
                           1'b0, dlmt_pkg::ROW_W'($urandom),
                           dlmt_pkg::CODE_W'($urandom_range(255)));
            if ($urandom_range(99) < 90)
                from = state_set[$urandom_range(state_set.size() - 1)];
            else
                from = dlmt_pkg::ROW_W'($urandom_range(63));
            len = $urandom_range(12);
            scan_char(1'b1, from, pick_letter());
            repeat (len) begin
                if ($urandom_range(99) < 4)
                    write_cell(dlmt_pkg::ROW_W'($urandom), dlmt_pkg::COL_W'($urandom),
                               dlmt_pkg::CELL_W'($urandom));
                scan_char(1'b0, dlmt_pkg::ROW_W'($urandom), pick_letter());
            end
            roll = $urandom_range(99);
            if (roll < 40)
                scan_char(1'b0, dlmt_pkg::ROW_W'($urandom), dlmt_pkg::NUL_CHAR);
            else if (roll < 75)
                scan_char(1'b0, dlmt_pkg::ROW_W'($urandom),
                          dlmt_pkg::CODE_W'($urandom_range(255, 128)));
        end
    endtask

    task automatic test_random_tokens();
        int first_beat;
        first_beat = beats_sent;
        while (beats_sent - first_beat < 1620) begin
            quiet = (beats_sent - first_beat > 700) && (beats_sent - first_beat < 1150);
            random_round();
        end
        quiet = 1'b0;
    endtask

    initial begin
        mismatches     = 0;
        beats_sent     = 0;
        quiet          = 1'b0;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_operation    = dlmt_pkg::OP_WRITE;
        i_table_row    = '0;
        i_table_column = '0;
        i_cell_value   = '0;
        i_first_char   = 1'b0;
        i_start_state  = '0;
        i_char_code    = '0;
        for (int r = 0; r < dlmt_pkg::NUM_STATES; r++)
            for (int c = 0; c < dlmt_pkg::NUM_SYMBOLS; c++)
                cell_table[r][c] = -1;
        dfa_state = '0;
        scan_on   = 1'b0;
        scanned   = '0;
        longest   = '0;
        accepted  = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_long_scan();
        test_random_tokens();

        i_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("dfa_longest_match_tokenizer_top test passed");
        else
            $display("dfa_longest_match_tokenizer_top test failed");
        $finish;
    end

endmodule

// ----- sim.f -----
src/dlmt_pkg.sv
src/dlmt_ram.sv
src/dlmt_clear.sv
src/dlmt_scan.sv
src/dfa_longest_match_tokenizer_top.sv
verif/dfa_longest_match_tokenizer_top_test.sv
